// ===== rtl/smx_pkg.sv =====
package smx_pkg;

   localparam int STACK_DEPTH = 64;
   localparam int SP_W = $clog2(STACK_DEPTH + 1);
   localparam int WORD_W = 32;

   typedef enum logic [3:0] {
      OP_HALT = 4'd0,
      OP_PUSH = 4'd1,
      OP_OUT  = 4'd2,
      OP_ADD  = 4'd3,
      OP_SUB  = 4'd4,
      OP_MUL  = 4'd5,
      OP_DIV  = 4'd6,
      OP_SQRT = 4'd7
   } opcode_type;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_UNKNOWN = 3'd1;
   localparam logic [2:0] ST_STACK   = 3'd2;
   localparam logic [2:0] ST_DIVZERO = 3'd3;
   localparam logic [2:0] ST_SQRTNEG = 3'd4;
   localparam logic [2:0] ST_HALTED  = 3'd5;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_TAKE_UP,
      CELL_TAKE_DOWN
   } cell_cmd_type;

   typedef struct packed {
      logic start;
      logic is_sqrt;
      logic neg;
   } du_ctl_type;

endpackage

// ===== rtl/stack_machine_executor.sv =====
// halt, push, out, add, sub, mul and unknown opcodes are answered straight from the idle state;
// divide by zero passes through the S_POPX state, and sqrt and divide wait in S_BUSY on the
// iterative divide/sqrt unit (one quotient bit or one root bit per cycle)
// one item at a time: a new item is taken once the previous finishes and the response register is empty or being taken
// reset: synchronous, empties the stack and clears the halted flag
module stack_machine_executor (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [3:0]                        req_func,
   input  logic signed [smx_pkg::WORD_W-1:0] req_immediate,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [2:0]                        rsp_status,
   output logic                              rsp_out_valid,
   output logic signed [smx_pkg::WORD_W-1:0] rsp_out_value,
   output logic                              rsp_halted_flag
);
   import smx_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_BUSY,
      S_POPX
   } state_type;

   state_type         state_ff, state_in;
   logic [SP_W-1:0]   sp_ff, sp_in;
   logic              halted_ff, halted_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [2:0]        status_ff, status_in;
   logic              ovalid_ff, ovalid_in;
   logic [WORD_W-1:0] ovalue_ff, ovalue_in;
   logic              req_func_div_ff;

   logic              acc;
   logic              rsp_free;
   logic              emit;
   cell_cmd_type      cmd_top;
   cell_cmd_type      cmd_rest;
   logic [WORD_W-1:0] top_data;
   logic [WORD_W-1:0] words [STACK_DEPTH];
   logic [WORD_W-1:0] tos;
   logic [WORD_W-1:0] nos;
   logic [WORD_W-1:0] mag_a, mag_b;
   logic [WORD_W-1:0] prod;
   du_ctl_type        du_ctl;
   logic              du_busy;
   logic [WORD_W-1:0] du_result;

   assign tos      = words[0];
   assign nos      = words[1];
   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE) || !rsp_free;
   assign acc      = req_valid && !req_stall;
   assign mag_a    = nos[WORD_W-1] ? (WORD_W'(0) - nos) : nos;
   assign mag_b    = tos[WORD_W-1] ? (WORD_W'(0) - tos) : tos;
   assign prod     = WORD_W'(nos * tos);

   always_comb begin
      state_in  = state_ff;
      sp_in     = sp_ff;
      halted_in = halted_ff;
      status_in = ST_OK;
      ovalid_in = 1'b0;
      ovalue_in = '0;
      emit      = 1'b0;
      cmd_top   = CELL_HOLD;
      cmd_rest  = CELL_HOLD;
      top_data  = req_immediate;
      du_ctl    = '{start: 1'b0, is_sqrt: 1'b0, neg: 1'b0};
      unique case (state_ff)
         S_IDLE: begin
            if (acc) begin
               emit = 1'b1;
               if (halted_ff) begin
                  status_in = ST_HALTED;
               end else begin
                  case (req_func) inside
                     OP_HALT: halted_in = 1'b1;
                     OP_PUSH: begin
                        if (sp_ff == SP_W'(STACK_DEPTH)) begin
                           status_in = ST_STACK;
                        end else begin
                           cmd_top  = CELL_TAKE_UP;
                           cmd_rest = CELL_TAKE_UP;
                           sp_in    = sp_ff + 1'b1;
                        end
                     end
                     OP_OUT: begin
                        if (sp_ff == '0) begin
                           status_in = ST_STACK;
                        end else begin
                           ovalid_in = 1'b1;
                           ovalue_in = tos;
                           cmd_top   = CELL_TAKE_DOWN;
                           cmd_rest  = CELL_TAKE_DOWN;
                           sp_in     = sp_ff - 1'b1;
                        end
                     end
                     OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                        if (sp_ff == '0) begin
                           status_in = ST_STACK;
                        end else if (sp_ff == SP_W'(1)) begin
                           status_in = ST_STACK;
                           cmd_top   = CELL_TAKE_DOWN;
                           cmd_rest  = CELL_TAKE_DOWN;
                           sp_in     = '0;
                        end else if (req_func == OP_DIV) begin
                           emit = 1'b0;
                           if (tos == '0) begin
                              cmd_top  = CELL_TAKE_DOWN;
                              cmd_rest = CELL_TAKE_DOWN;
                              sp_in    = sp_ff - 1'b1;
                              state_in = S_POPX;
                           end else begin
                              du_ctl   = '{start: 1'b1, is_sqrt: 1'b0,
                                           neg: nos[WORD_W-1] ^ tos[WORD_W-1]};
                              state_in = S_BUSY;
                           end
                        end else begin
                           if (req_func == OP_ADD) begin
                              top_data = nos + tos;
                           end else if (req_func == OP_SUB) begin
                              top_data = nos - tos;
                           end else begin
                              top_data = prod;
                           end
                           cmd_top  = CELL_TAKE_UP;
                           cmd_rest = CELL_TAKE_DOWN;
                           sp_in    = sp_ff - 1'b1;
                        end
                     end
                     OP_SQRT: begin
                        if (sp_ff == '0) begin
                           status_in = ST_STACK;
                        end else if (tos[WORD_W-1]) begin
                           status_in = ST_SQRTNEG;
                           cmd_top   = CELL_TAKE_DOWN;
                           cmd_rest  = CELL_TAKE_DOWN;
                           sp_in     = sp_ff - 1'b1;
                        end else begin
                           emit     = 1'b0;
                           du_ctl   = '{start: 1'b1, is_sqrt: 1'b1, neg: 1'b0};
                           state_in = S_BUSY;
                        end
                     end
                     default: status_in = ST_UNKNOWN;
                  endcase
               end
            end
         end
         S_BUSY: begin
            top_data = du_result;
            if (!du_busy && rsp_free) begin
               emit     = 1'b1;
               cmd_top  = CELL_TAKE_UP;
               state_in = S_IDLE;
               if (sp_ff != SP_W'(1)) begin
                  cmd_rest = CELL_HOLD;
               end
               if (req_func_div_ff) begin
                  cmd_rest = CELL_TAKE_DOWN;
                  sp_in    = sp_ff - 1'b1;
               end
            end
         end
         S_POPX: begin
            if (rsp_free) begin
               emit      = 1'b1;
               status_in = ST_DIVZERO;
               cmd_top   = CELL_TAKE_DOWN;
               cmd_rest  = CELL_TAKE_DOWN;
               sp_in     = sp_ff - 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      rsp_valid_in = emit ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sp_ff        <= '0;
         halted_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sp_ff        <= sp_in;
         halted_ff    <= halted_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (du_ctl.start) begin
         req_func_div_ff <= !du_ctl.is_sqrt;
      end
      if (emit) begin
         status_ff <= status_in;
         ovalid_ff <= ovalid_in;
         ovalue_ff <= ovalue_in;
      end
   end

   smx_divsqrt u_divsqrt (
      .clock  (clock),
      .reset  (reset),
      .ctl    (du_ctl),
      .op_a   (du_ctl.is_sqrt ? tos : mag_a),
      .op_b   (mag_b),
      .busy   (du_busy),
      .result (du_result)
   );

   for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
      logic [WORD_W-1:0] up_w;
      logic [WORD_W-1:0] down_w;
      if (i == 0) begin : g_first
         assign up_w = top_data;
      end else begin : g_mid
         assign up_w = words[i-1];
      end
      if (i == STACK_DEPTH - 1) begin : g_last
         assign down_w = '0;
      end else begin : g_inner
         assign down_w = words[i+1];
      end
      smx_cell u_cell (
         .clock     (clock),
         .cmd       ((i == 0) ? cmd_top : cmd_rest),
         .up_word   (up_w),
         .down_word (down_w),
         .word      (words[i])
      );
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_out_valid   = ovalid_ff;
   assign rsp_out_value   = ovalue_ff;
   assign rsp_halted_flag = halted_ff;

   a_sp_bound: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= SP_W'(STACK_DEPTH))
      else $error("stack pointer beyond depth");

   a_halt_sticks: assert property (@(posedge clock) disable iff (reset)
      halted_ff |=> halted_ff)
      else $error("halted flag cleared without reset");

   a_unit_idle: assert property (@(posedge clock) disable iff (reset)
      acc |-> !du_busy)
      else $error("item accepted while divide/sqrt unit busy");

   a_out_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_out_valid) |-> (rsp_status == ST_OK))
      else $error("popped value reported with error status");

endmodule

// ===== rtl/smx_cell.sv =====
module smx_cell (
   input  logic                             clock,
   input  smx_pkg::cell_cmd_type            cmd,
   input  logic [smx_pkg::WORD_W-1:0]       up_word,
   input  logic [smx_pkg::WORD_W-1:0]       down_word,
   output logic [smx_pkg::WORD_W-1:0]       word
);
   import smx_pkg::*;

   logic [WORD_W-1:0] word_ff;
   logic [WORD_W-1:0] word_in;

   always_comb begin
      case (cmd)
         CELL_TAKE_UP:   word_in = up_word;
         CELL_TAKE_DOWN: word_in = down_word;
         default:        word_in = word_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word = word_ff;

endmodule

// ===== rtl/smx_divsqrt.sv =====
module smx_divsqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  smx_pkg::du_ctl_type           ctl,
   input  logic [smx_pkg::WORD_W-1:0]    op_a,
   input  logic [smx_pkg::WORD_W-1:0]    op_b,
   output logic                          busy,
   output logic [smx_pkg::WORD_W-1:0]    result
);
   import smx_pkg::*;

   localparam int CNT_W = $clog2(WORD_W);

   logic              busy_ff, busy_in;
   logic              sqrt_ff, sqrt_in;
   logic              neg_ff, neg_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [WORD_W:0]   a_ff, a_in;
   logic [WORD_W-1:0] b_ff, b_in;
   logic [WORD_W-1:0] c_ff, c_in;
   logic [WORD_W:0]   rem_sh;
   logic [WORD_W:0]   diff;
   logic [WORD_W:0]   trial;

   always_comb begin
      busy_in = busy_ff;
      sqrt_in = sqrt_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      c_in    = c_ff;
      rem_sh  = {a_ff[WORD_W-1:0], b_ff[WORD_W-1]};
      diff    = rem_sh - {1'b0, c_ff};
      trial   = {1'b0, b_ff} + {1'b0, c_ff};
      if (ctl.start) begin
         busy_in = 1'b1;
         sqrt_in = ctl.is_sqrt;
         neg_in  = ctl.neg;
         if (ctl.is_sqrt) begin
            cnt_in = CNT_W'(WORD_W / 2 - 1);
            a_in   = {1'b0, op_a};
            b_in   = '0;
            c_in   = WORD_W'(1) << (WORD_W - 2);
         end else begin
            cnt_in = CNT_W'(WORD_W - 1);
            a_in   = '0;
            b_in   = op_a;
            c_in   = op_b;
         end
      end else if (busy_ff) begin
         if (sqrt_ff) begin
            if (a_ff >= trial) begin
               a_in = a_ff - trial;
               b_in = (b_ff >> 1) + c_ff;
            end else begin
               b_in = b_ff >> 1;
            end
            c_in = c_ff >> 2;
         end else begin
            if (!diff[WORD_W]) begin
               a_in = diff;
               b_in = {b_ff[WORD_W-2:0], 1'b1};
            end else begin
               a_in = rem_sh;
               b_in = {b_ff[WORD_W-2:0], 1'b0};
            end
         end
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      sqrt_ff <= sqrt_in;
      neg_ff  <= neg_in;
      cnt_ff  <= cnt_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      c_ff    <= c_in;
   end

   assign busy   = busy_ff;
   assign result = (!sqrt_ff && neg_ff) ? (WORD_W'(0) - b_ff) : b_ff;

endmodule
